@@ sv/mbet_pkg.sv @@
// Shared constants, types and tables of the Mandelbrot escape-time pixel block.
package mbet_pkg;

  localparam int MAX_ITERATIONS = 100;
  localparam int MAX_DIMENSION  = 4096;
  localparam int FRACTION_BITS  = 28;

  localparam int GRAY_DIVISOR = 50;
  localparam int GRAY_SCALE   = 256;

  // Port widths fixed by the field definitions
  localparam int PIX_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 7;
  localparam int GRAY_W    = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Fixed point Q4.F and derived widths
  localparam int FX_W   = FRACTION_BITS + 4;
  localparam int PROD_W = 2 * FX_W;
  localparam int SQ_W   = PROD_W - FRACTION_BITS;      // floor(a*a / 2^F)
  localparam int CROSS_W = PROD_W - FRACTION_BITS + 1; // floor(2*a*b / 2^F)
  localparam int NUM_W  = PIX_W + 1 + FRACTION_BITS;   // (2*pixel) << F
  localparam int DEN_W  = $clog2(MAX_DIMENSION + 1);
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int CNT_W  = $clog2(MAX_ITERATIONS + 1);
  localparam int WIDE_W = (NUM_W + 1 > CROSS_W + 2) ? NUM_W + 1 : CROSS_W + 2;

  localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] FX_MAX_W = {{(WIDE_W-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] FX_MIN_W = {{(WIDE_W-FX_W+1){1'b1}}, {(FX_W-1){1'b0}}};

  localparam logic signed [WIDE_W-1:0] RE_OFFSET = WIDE_W'(3) << (FRACTION_BITS - 1);
  localparam logic signed [WIDE_W-1:0] IM_OFFSET = WIDE_W'(1) << FRACTION_BITS;
  localparam logic signed [WIDE_W-1:0] ESC_LIMIT = WIDE_W'(4) << FRACTION_BITS;

  localparam logic [CNT_W-1:0] ITER_LIMIT = CNT_W'(MAX_ITERATIONS);

  typedef logic [2**CNT_W-1:0][GRAY_W-1:0] gray_lut_t;

  function automatic gray_lut_t build_gray_lut();
    gray_lut_t lut;
    for (int i = 0; i < 2**CNT_W; i++) begin
      lut[i] = GRAY_W'((i * GRAY_SCALE) / GRAY_DIVISOR);
    end
    return lut;
  endfunction

  localparam gray_lut_t GRAY_LUT = build_gray_lut();

  // Clamp a wide signed value into the Q4.F range
  function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [WIDE_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v > FX_MAX_W) begin
      r = FX_MAX;
    end else if (v < FX_MIN_W) begin
      r = FX_MIN;
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;  // start both coordinate divisions
    logic init;  // set c from the quotients, clear z and count
    logic mul;   // register the three products
    logic step;  // advance z and count
    logic emit;  // load the result word
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic escape;
  } dp_sts_t;

endpackage

@@ sv/mbet_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module mbet_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mbet_pkg::NUM_W-1:0]      numer_i,
  input  logic [mbet_pkg::DEN_W-1:0]      denom_i,
  output logic                            busy_o,
  output logic [mbet_pkg::NUM_W-1:0]      quot_o
);

  logic                             busy_q, busy_d;
  logic [mbet_pkg::DCNT_W-1:0]      cnt_q, cnt_d;
  logic [mbet_pkg::DEN_W-1:0]       den_q, den_d;
  logic [mbet_pkg::DEN_W-1:0]       rem_q, rem_d;
  logic [mbet_pkg::NUM_W-1:0]       acc_q, acc_d;
  logic [mbet_pkg::DEN_W:0]         trial;
  logic                             fits;

  assign trial = {rem_q, acc_q[mbet_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mbet_pkg::DCNT_W'(mbet_pkg::NUM_W);
      den_d  = denom_i;
      rem_d  = '0;
      acc_d  = numer_i;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract where the divisor fits
      rem_d = fits ? mbet_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[mbet_pkg::DEN_W-1:0];
      acc_d = {acc_q[mbet_pkg::NUM_W-2:0], fits};
      cnt_d = cnt_q - mbet_pkg::DCNT_W'(1);
      if (cnt_q == mbet_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q;

endmodule

@@ sv/mbet_dp.sv @@
// Datapath: configuration registers, coordinate dividers, iteration and result registers.
module mbet_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbet_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [mbet_pkg::PIX_W-1:0]        pixel_x_i,
  input  logic [mbet_pkg::PIX_W-1:0]        pixel_y_i,
  input  mbet_pkg::dp_cmd_t                 cmd_i,
  output mbet_pkg::dp_sts_t                 sts_o,
  output logic [mbet_pkg::COUNT_W-1:0]      iteration_count_o,
  output logic [mbet_pkg::GRAY_W-1:0]       gray_level_o
);

  logic [mbet_pkg::CFG_W-1:0] width_q, width_d;
  logic [mbet_pkg::CFG_W-1:0] height_q, height_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbet_pkg::CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        mbet_pkg::CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbet_pkg::CFG_W'(512);
      height_q <= mbet_pkg::CFG_W'(512);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  function automatic logic [mbet_pkg::DEN_W-1:0] clamp_dim(input logic [mbet_pkg::CFG_W-1:0] d);
    logic [mbet_pkg::DEN_W-1:0] r;
    if (d == '0) begin
      r = mbet_pkg::DEN_W'(1);
    end else if (32'(d) > mbet_pkg::MAX_DIMENSION) begin
      r = mbet_pkg::DEN_W'(mbet_pkg::MAX_DIMENSION);
    end else begin
      r = mbet_pkg::DEN_W'(d);
    end
    return r;
  endfunction

  logic [mbet_pkg::NUM_W-1:0] numer_x, numer_y, quot_x, quot_y;
  logic                       busy_x, busy_y;

  assign numer_x = {pixel_x_i, 1'b0, {mbet_pkg::FRACTION_BITS{1'b0}}};
  assign numer_y = {pixel_y_i, 1'b0, {mbet_pkg::FRACTION_BITS{1'b0}}};

  mbet_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .numer_i (numer_x),
    .denom_i (clamp_dim(width_q)),
    .busy_o  (busy_x),
    .quot_o  (quot_x)
  );

  mbet_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .numer_i (numer_y),
    .denom_i (clamp_dim(height_q)),
    .busy_o  (busy_y),
    .quot_o  (quot_y)
  );

  logic signed [mbet_pkg::FX_W-1:0]   cre_q, cim_q, zre_q, zim_q;
  logic signed [mbet_pkg::FX_W-1:0]   cre_d, cim_d, zre_d, zim_d;
  logic signed [mbet_pkg::PROD_W-1:0] psr_q, psi_q, pcr_q;
  logic [mbet_pkg::CNT_W-1:0]         count_q, count_d;
  logic [mbet_pkg::COUNT_W-1:0]       iter_q;
  logic [mbet_pkg::GRAY_W-1:0]        gray_q;

  logic signed [mbet_pkg::SQ_W-1:0]    sr, si;
  logic signed [mbet_pkg::CROSS_W-1:0] cross_term;
  logic signed [mbet_pkg::WIDE_W-1:0]  mag, re_sum, im_sum;

  // floor shifts of the exact products
  assign sr         = psr_q[mbet_pkg::PROD_W-1:mbet_pkg::FRACTION_BITS];
  assign si         = psi_q[mbet_pkg::PROD_W-1:mbet_pkg::FRACTION_BITS];
  assign cross_term = pcr_q[mbet_pkg::PROD_W-1:mbet_pkg::FRACTION_BITS-1];

  assign mag    = mbet_pkg::WIDE_W'(sr) + mbet_pkg::WIDE_W'(si);
  assign re_sum = mbet_pkg::WIDE_W'(sr) - mbet_pkg::WIDE_W'(si) + mbet_pkg::WIDE_W'(cre_q);
  assign im_sum = mbet_pkg::WIDE_W'(cross_term) + mbet_pkg::WIDE_W'(cim_q);

  always_comb begin
    cre_d   = cre_q;
    cim_d   = cim_q;
    zre_d   = zre_q;
    zim_d   = zim_q;
    count_d = count_q;
    if (cmd_i.init) begin
      cre_d   = mbet_pkg::fx_sat($signed({1'b0, quot_x}) - mbet_pkg::RE_OFFSET);
      cim_d   = mbet_pkg::fx_sat($signed({1'b0, quot_y}) - mbet_pkg::IM_OFFSET);
      zre_d   = '0;
      zim_d   = '0;
      count_d = '0;
    end else if (cmd_i.step) begin
      zre_d   = mbet_pkg::fx_sat(re_sum);
      zim_d   = mbet_pkg::fx_sat(im_sum);
      count_d = count_q + mbet_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cre_q   <= cre_d;
    cim_q   <= cim_d;
    zre_q   <= zre_d;
    zim_q   <= zim_d;
    count_q <= count_d;
    if (cmd_i.mul) begin
      psr_q <= zre_q * zre_q;
      psi_q <= zim_q * zim_q;
      pcr_q <= zre_q * zim_q;
    end
    if (cmd_i.emit) begin
      iter_q <= mbet_pkg::COUNT_W'(count_q);
      gray_q <= mbet_pkg::GRAY_LUT[count_q];
    end
  end

  assign sts_o.div_busy = busy_x | busy_y;
  assign sts_o.escape   = (mag >= mbet_pkg::ESC_LIMIT) || (count_q == mbet_pkg::ITER_LIMIT);

  assign iteration_count_o = iter_q;
  assign gray_level_o      = gray_q;

endmodule

@@ sv/mbet_ctrl.sv @@
// Controller: sequences division, iteration and result hand-off.
module mbet_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mbet_pkg::dp_sts_t sts_i,
  output mbet_pkg::dp_cmd_t cmd_o
);

  mbet_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbet_pkg::ST_IDLE: if (in_valid_i) state_d = mbet_pkg::ST_DIV;
      mbet_pkg::ST_DIV:  if (!sts_i.div_busy) state_d = mbet_pkg::ST_MUL;
      mbet_pkg::ST_MUL:  state_d = mbet_pkg::ST_UPD;
      mbet_pkg::ST_UPD:  state_d = sts_i.escape ? mbet_pkg::ST_FIN : mbet_pkg::ST_MUL;
      mbet_pkg::ST_FIN:  if (out_free) state_d = mbet_pkg::ST_IDLE;
      default:           state_d = mbet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mbet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mbet_pkg::ST_DIV: cmd_o.init = !sts_i.div_busy;
      mbet_pkg::ST_MUL: cmd_o.mul  = 1'b1;
      mbet_pkg::ST_UPD: cmd_o.step = !sts_i.escape;
      mbet_pkg::ST_FIN: cmd_o.emit = out_free;
      default: ;
    endcase
  end

  // hold the word until taken, reload when the next one is ready
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbet_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/mandelbrot_escape_time_pixel.sv @@
// Top level of the Mandelbrot escape-time pixel evaluator.
//
//   channel  signals                                   direction
//   in       in_valid_i/in_ready_o, pixel_x_i, pixel_y_i      in
//   out      out_valid_o/out_ready_i, iteration_count_o,
//            gray_level_o                                      out
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i                 in
//
// A pixel runs the division, then N iterations (N the count, at most 100):
// the two coordinate dividers give one quotient bit a cycle over 41 bits,
// and each iteration passes the three multipliers in ST_MUL, then the add,
// saturate and escape compare in ST_UPD. One pixel is in work at a time; the
// result word waits in an output register, so the next pixel is taken while it
// stalls. Reset sets width and height to 512 and leaves the block idle.
module mandelbrot_escape_time_pixel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbet_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mbet_pkg::PIX_W-1:0]        pixel_x_i,
  input  logic [mbet_pkg::PIX_W-1:0]        pixel_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mbet_pkg::COUNT_W-1:0]      iteration_count_o,
  output logic [mbet_pkg::GRAY_W-1:0]       gray_level_o
);

  mbet_pkg::dp_cmd_t cmd;
  mbet_pkg::dp_sts_t sts;

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbet_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .iteration_count_o (iteration_count_o),
    .gray_level_o      (gray_level_o)
  );

endmodule
